@@ hw/rtl/rdlss_pkg.sv @@
// Shared types and constants for the reverse-diffusion Langevin step block.
package rdlss_pkg;

	// Item field widths
	localparam int MODE_W   = 3;
	localparam int WALKER_W = 2;
	localparam int ROW_W    = 4;
	localparam int COL_W    = 4;
	localparam int VALUE_W  = 24;
	localparam int GAIN_W   = 24;

	// Input tdata and output tdata widths, padded to whole bytes
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 32;

	// Configuration port
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	// Register indexes
	localparam logic [1:0] REG_KEEP_GAIN  = 2'd0;
	localparam logic [1:0] REG_SCORE_GAIN = 2'd1;
	localparam logic [1:0] REG_NOISE_GAIN = 2'd2;

	// Register reset values
	localparam logic [GAIN_W-1:0] KEEP_GAIN_RST  = 24'd66191;
	localparam logic [GAIN_W-1:0] SCORE_GAIN_RST = 24'd1311;
	localparam logic [GAIN_W-1:0] NOISE_GAIN_RST = 24'd9268;

	// Item modes
	typedef enum logic [MODE_W-1:0] {
		MODE_SET_WALKER = 3'd0,
		MODE_SET_WEIGHT = 3'd1,
		MODE_SET_OFFSET = 3'd2,
		MODE_COMPUTE    = 3'd3,
		MODE_COMMIT     = 3'd4
	} mode_t;

	// Gain phase steps of the shared multiplier
	localparam logic [2:0] GSTEP_KEEP     = 3'd0;
	localparam logic [2:0] GSTEP_SCORE_LO = 3'd1;
	localparam logic [2:0] GSTEP_SCORE_HI = 3'd2;
	localparam logic [2:0] GSTEP_NOISE    = 3'd3;
	localparam logic [2:0] GSTEP_DONE     = 3'd4;

	// Datapath widths
	localparam int MUL_W  = 25;
	localparam int PROD_W = 50;
	localparam int ACC_W  = 64;
	localparam int DOT_W  = 39;
	localparam int HI_W   = 15;

	// Saturation limits of a Q8.16 result
	localparam logic [VALUE_W-1:0] SAT_MAX = 24'h7FFFFF;
	localparam logic [VALUE_W-1:0] SAT_MIN = 24'h800000;

endpackage

@@ hw/rtl/rdlss_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rdlss_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/reverse_diffusion_linear_score_step_top.sv @@
// Top level of the reverse-diffusion Langevin step block with a linear score.
//
// Usage: items arrive on the s_ stream; s_tuser carries the mode. Load items
// (set walker component, set weight, set offset) write their store in the
// cycle they are accepted and give no result. A compute item for walker w,
// component i, takes a noise sample in the value field, forms
//   keep*x[i] + score*(b[i] + sum_k W[i][k]*x[k]) + noise*sample
// in Q8.16, writes it to the next buffer and sends one result item on the m_
// stream, saturated with m_tuser set when clipped. A commit item copies the
// next buffer into the current buffer and gives no result.
// A compute item runs DIM weight products and then four gain products on one
// shared 25x25 multiplier. A commit copies one entry per cycle through the
// RAM ports.
// s_tready is low while an item is in work. The result sits in an output
// register; a stalled receiver holds it there, and a following compute item
// waits at its last step until that register is free.
// Reset clears control state and loads the gain registers with their reset
// values; the stores hold nothing defined until written.
module reverse_diffusion_linear_score_step_top #(
	parameter int DIM     = 16,
	parameter int WALKERS = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [1:0] walker, [5:2] row, [9:6] col, [33:10] value, [39:34] zero
	input  logic [rdlss_pkg::S_TDATA_W-1:0]  s_tdata,
	// [2:0] mode
	input  logic [rdlss_pkg::MODE_W-1:0]     s_tuser,
	// Output stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [1:0] out_walker, [5:2] out_row, [29:6] new_value, [31:30] zero
	output logic [rdlss_pkg::M_TDATA_W-1:0]  m_tdata,
	// [0] saturated
	output logic                             m_tuser,
	// Configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [rdlss_pkg::APB_AW-1:0]     paddr,
	input  logic [rdlss_pkg::APB_DW-1:0]     pwdata,
	output logic [rdlss_pkg::APB_DW-1:0]     prdata,
	output logic                             pready
);

	localparam int NWK    = WALKERS * DIM;
	localparam int NWT    = DIM * DIM;
	localparam int WK_AW  = (NWK > 1) ? $clog2(NWK) : 1;
	localparam int WT_AW  = (NWT > 1) ? $clog2(NWT) : 1;
	localparam int OFF_AW = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int KW     = $clog2(DIM + 1);
	localparam int CW     = $clog2(NWK + 1);
	localparam int VW     = rdlss_pkg::VALUE_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DOT,
		ST_ROUND,
		ST_GAIN,
		ST_FIN,
		ST_COPY
	} state_t;

	state_t state_q;

	// Input field split
	logic [rdlss_pkg::WALKER_W-1:0] in_walker;
	logic [rdlss_pkg::ROW_W-1:0]    in_row;
	logic [rdlss_pkg::COL_W-1:0]    in_col;
	logic [VW-1:0]                  in_value;
	rdlss_pkg::mode_t               in_mode;
	logic                           in_acc;
	logic                           row_ok;
	logic                           col_ok;
	logic                           walker_ok;

	assign in_walker = s_tdata[1:0];
	assign in_row    = s_tdata[5:2];
	assign in_col    = s_tdata[9:6];
	assign in_value  = s_tdata[33:10];
	assign in_mode   = rdlss_pkg::mode_t'(s_tuser);
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign row_ok    = (32'(in_row) < DIM);
	assign col_ok    = (32'(in_col) < DIM);
	assign walker_ok = (32'(in_walker) < WALKERS);

	// Gain registers and read-back
	logic [rdlss_pkg::GAIN_W-1:0] keep_gain_q;
	logic [rdlss_pkg::GAIN_W-1:0] score_gain_q;
	logic [rdlss_pkg::GAIN_W-1:0] noise_gain_q;
	logic                         cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_gain_q  <= rdlss_pkg::KEEP_GAIN_RST;
			score_gain_q <= rdlss_pkg::SCORE_GAIN_RST;
			noise_gain_q <= rdlss_pkg::NOISE_GAIN_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				rdlss_pkg::REG_KEEP_GAIN:  keep_gain_q  <= pwdata[23:0];
				rdlss_pkg::REG_SCORE_GAIN: score_gain_q <= pwdata[23:0];
				rdlss_pkg::REG_NOISE_GAIN: noise_gain_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			rdlss_pkg::REG_KEEP_GAIN:  prdata = {8'd0, keep_gain_q};
			rdlss_pkg::REG_SCORE_GAIN: prdata = {8'd0, score_gain_q};
			rdlss_pkg::REG_NOISE_GAIN: prdata = {8'd0, noise_gain_q};
			default:                   prdata = '0;
		endcase
	end

	// Sequencer and datapath registers
	logic [rdlss_pkg::WALKER_W-1:0] walker_q;
	logic [rdlss_pkg::ROW_W-1:0]    row_q;
	logic [VW-1:0]                  noise_q;
	logic [KW-1:0]                  issue_k_q;
	logic                           rd_v_s1;
	logic                           first_s1;
	logic [KW-1:0]                  k_s1;
	logic [VW-1:0]                  xrow_q;
	logic [2:0]                     gstep_q;
	logic                           mul_v_s2;
	logic                           sh_s2;
	logic signed [rdlss_pkg::PROD_W-1:0] prod_s2;
	logic signed [rdlss_pkg::ACC_W-1:0]  acc_q;
	logic [rdlss_pkg::DOT_W-1:0]    dot_q;
	logic [CW-1:0]                  cp_k_q;
	logic                           cp_v_s1;
	logic [WK_AW-1:0]               cp_a_s1;

	// Output register and the rounded, saturated result feeding it
	logic                           m_tvalid_q;
	logic [rdlss_pkg::WALKER_W-1:0] out_walker_q;
	logic [rdlss_pkg::ROW_W-1:0]    out_row_q;
	logic [VW-1:0]                  new_value_q;
	logic                           saturated_q;
	logic [VW-1:0]                  new_value_c;
	logic                           sat_c;

	// RAM ports
	logic             now_we;
	logic [WK_AW-1:0] now_waddr;
	logic [VW-1:0]    now_wdata;
	logic [WK_AW-1:0] now_raddr;
	logic [VW-1:0]    now_rdata;
	logic             nxt_we;
	logic [WK_AW-1:0] nxt_waddr;
	logic [WK_AW-1:0] nxt_raddr;
	logic [VW-1:0]    nxt_rdata;
	logic             wt_we;
	logic [WT_AW-1:0] wt_waddr;
	logic [WT_AW-1:0] wt_raddr;
	logic [VW-1:0]    wt_rdata;
	logic             off_we;
	logic [OFF_AW-1:0] off_waddr;
	logic [OFF_AW-1:0] off_raddr;
	logic [VW-1:0]    off_rdata;

	logic dot_issue;
	logic dot_done;
	logic gain_done;
	logic fin_go;
	logic cp_issue;
	logic cp_done;

	assign dot_issue = (state_q == ST_DOT) && (32'(issue_k_q) < DIM);
	assign dot_done  = (32'(issue_k_q) == DIM) && !rd_v_s1 && !mul_v_s2;
	assign gain_done = (gstep_q == rdlss_pkg::GSTEP_DONE) && !mul_v_s2;
	assign fin_go    = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);
	assign cp_issue  = (state_q == ST_COPY) && (32'(cp_k_q) < NWK);
	assign cp_done   = (32'(cp_k_q) == NWK) && !cp_v_s1;

	// Current walker store: load writes, commit copies, dot reads
	assign now_we    = (in_acc && in_mode == rdlss_pkg::MODE_SET_WALKER && row_ok && walker_ok)
	                   || cp_v_s1;
	assign now_waddr = cp_v_s1 ? cp_a_s1
	                   : WK_AW'(32'(in_walker) * DIM + 32'(in_row));
	assign now_wdata = cp_v_s1 ? nxt_rdata : in_value;
	assign now_raddr = WK_AW'(32'(walker_q) * DIM + 32'(issue_k_q));

	// Next walker store: written at the end of a compute, read by commit
	assign nxt_we    = fin_go;
	assign nxt_waddr = WK_AW'(32'(walker_q) * DIM + 32'(row_q));
	assign nxt_raddr = WK_AW'(cp_k_q);

	// Weights and offsets
	assign wt_we     = in_acc && in_mode == rdlss_pkg::MODE_SET_WEIGHT && row_ok && col_ok;
	assign wt_waddr  = WT_AW'(32'(in_row) * DIM + 32'(in_col));
	assign wt_raddr  = WT_AW'(32'(row_q) * DIM + 32'(issue_k_q));
	assign off_we    = in_acc && in_mode == rdlss_pkg::MODE_SET_OFFSET && row_ok;
	assign off_waddr = OFF_AW'(in_row);
	assign off_raddr = OFF_AW'(row_q);

	rdlss_ram #(.WIDTH(VW), .DEPTH(NWK)) u_now_ram (
		.clk   (clk),
		.we    (now_we),
		.waddr (now_waddr),
		.wdata (now_wdata),
		.raddr (now_raddr),
		.rdata (now_rdata)
	);

	rdlss_ram #(.WIDTH(VW), .DEPTH(NWK)) u_next_ram (
		.clk   (clk),
		.we    (nxt_we),
		.waddr (nxt_waddr),
		.wdata (new_value_c),
		.raddr (nxt_raddr),
		.rdata (nxt_rdata)
	);

	rdlss_ram #(.WIDTH(VW), .DEPTH(NWT)) u_weight_ram (
		.clk   (clk),
		.we    (wt_we),
		.waddr (wt_waddr),
		.wdata (in_value),
		.raddr (wt_raddr),
		.rdata (wt_rdata)
	);

	rdlss_ram #(.WIDTH(VW), .DEPTH(DIM)) u_offset_ram (
		.clk   (clk),
		.we    (off_we),
		.waddr (off_waddr),
		.wdata (in_value),
		.raddr (off_raddr),
		.rdata (off_rdata)
	);

	// Shared multiplier operand select
	logic                                mul_issue;
	logic                                mul_sh;
	logic signed [rdlss_pkg::MUL_W-1:0]  mul_a;
	logic signed [rdlss_pkg::MUL_W-1:0]  mul_b;
	logic [rdlss_pkg::HI_W-1:0]          dot_hi;

	assign dot_hi = dot_q[rdlss_pkg::DOT_W-1:24];

	always_comb begin
		mul_issue = 1'b0;
		mul_sh    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		if (state_q == ST_DOT) begin
			mul_issue = rd_v_s1;
			mul_a     = {wt_rdata[VW-1], wt_rdata};
			mul_b     = {now_rdata[VW-1], now_rdata};
		end else if (state_q == ST_GAIN) begin
			case (gstep_q)
				rdlss_pkg::GSTEP_KEEP: begin
					mul_issue = 1'b1;
					mul_a     = {1'b0, keep_gain_q};
					mul_b     = {xrow_q[VW-1], xrow_q};
				end
				rdlss_pkg::GSTEP_SCORE_LO: begin
					mul_issue = 1'b1;
					mul_a     = {1'b0, score_gain_q};
					mul_b     = {1'b0, dot_q[23:0]};
				end
				rdlss_pkg::GSTEP_SCORE_HI: begin
					mul_issue = 1'b1;
					mul_sh    = 1'b1;
					mul_a     = {1'b0, score_gain_q};
					mul_b     = {{(rdlss_pkg::MUL_W - rdlss_pkg::HI_W){dot_hi[rdlss_pkg::HI_W-1]}},
					             dot_hi};
				end
				rdlss_pkg::GSTEP_NOISE: begin
					mul_issue = 1'b1;
					mul_a     = {1'b0, noise_gain_q};
					mul_b     = {noise_q[VW-1], noise_q};
				end
				default: ;
			endcase
		end
	end

	// Accumulator addend, rounding and saturation
	logic signed [rdlss_pkg::ACC_W-1:0] prod_ext;
	logic signed [rdlss_pkg::ACC_W-1:0] addend;
	logic signed [rdlss_pkg::ACC_W-1:0] off_init;
	logic signed [rdlss_pkg::ACC_W-1:0] rnd_sum;
	logic                               in_range;

	assign prod_ext = {{(rdlss_pkg::ACC_W - rdlss_pkg::PROD_W){prod_s2[rdlss_pkg::PROD_W-1]}},
	                   prod_s2};
	assign addend   = sh_s2 ? (prod_ext <<< 24) : prod_ext;
	assign off_init = {{(rdlss_pkg::ACC_W - VW - 16){off_rdata[VW-1]}}, off_rdata, 16'd0};
	assign rnd_sum  = acc_q + 64'sd32768;
	assign in_range = (rnd_sum[63:39] == '0) || (rnd_sum[63:39] == '1);
	assign sat_c    = !in_range;
	assign new_value_c = in_range ? rnd_sum[39:16]
	                     : (rnd_sum[63] ? rdlss_pkg::SAT_MIN : rdlss_pkg::SAT_MAX);

	// Multiplier stage
	always_ff @(posedge clk) begin
		prod_s2 <= mul_a * mul_b;
		sh_s2   <= mul_sh;
	end

	// Sequencer, datapath control and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			walker_q     <= '0;
			row_q        <= '0;
			noise_q      <= '0;
			issue_k_q    <= '0;
			rd_v_s1      <= 1'b0;
			first_s1     <= 1'b0;
			k_s1         <= '0;
			xrow_q       <= '0;
			gstep_q      <= '0;
			mul_v_s2     <= 1'b0;
			acc_q        <= '0;
			dot_q        <= '0;
			cp_k_q       <= '0;
			cp_v_s1      <= 1'b0;
			cp_a_s1      <= '0;
			m_tvalid_q   <= 1'b0;
			out_walker_q <= '0;
			out_row_q    <= '0;
			new_value_q  <= '0;
			saturated_q  <= 1'b0;
		end else begin
			mul_v_s2 <= mul_issue;
			rd_v_s1  <= dot_issue;
			first_s1 <= dot_issue && (issue_k_q == '0);
			k_s1     <= issue_k_q;
			cp_v_s1  <= cp_issue;
			cp_a_s1  <= WK_AW'(cp_k_q);

			// Drop the result once taken, unless a new one replaces it
			if (m_tvalid_q && m_tready && !fin_go) begin
				m_tvalid_q <= 1'b0;
			end

			// Accumulate products; seed with the offset, clear before gains
			if (state_q == ST_ROUND) begin
				acc_q <= '0;
			end else if (rd_v_s1 && first_s1) begin
				acc_q <= off_init;
			end else if (mul_v_s2) begin
				acc_q <= acc_q + addend;
			end

			// Capture the own component as it streams past
			if (rd_v_s1 && 32'(k_s1) == 32'(row_q)) begin
				xrow_q <= now_rdata;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						walker_q  <= in_walker;
						row_q     <= in_row;
						noise_q   <= in_value;
						issue_k_q <= '0;
						cp_k_q    <= '0;
						case (in_mode)
							rdlss_pkg::MODE_COMPUTE: begin
								if (row_ok && walker_ok) begin
									state_q <= ST_DOT;
								end
							end
							rdlss_pkg::MODE_COMMIT: state_q <= ST_COPY;
							default: ;
						endcase
					end
				end
				ST_DOT: begin
					if (dot_issue) begin
						issue_k_q <= issue_k_q + 1'b1;
					end
					if (dot_done) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					dot_q   <= rnd_sum[54:16];
					gstep_q <= rdlss_pkg::GSTEP_KEEP;
					state_q <= ST_GAIN;
				end
				ST_GAIN: begin
					if (gstep_q != rdlss_pkg::GSTEP_DONE) begin
						gstep_q <= gstep_q + 3'd1;
					end
					if (gain_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// Hold until the output register is free
					if (fin_go) begin
						m_tvalid_q   <= 1'b1;
						out_walker_q <= walker_q;
						out_row_q    <= row_q;
						new_value_q  <= new_value_c;
						saturated_q  <= sat_c;
						state_q      <= ST_IDLE;
					end
				end
				ST_COPY: begin
					if (cp_issue) begin
						cp_k_q <= cp_k_q + 1'b1;
					end
					if (cp_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, new_value_q, out_row_q, out_walker_q};
	assign m_tuser  = saturated_q;

endmodule
